FILE: sv/sld_pkg.sv
// Shared package for the sync/length/checksum deframer.
// Holds frame constants, field widths, the parser state type and the
// controller-to-datapath command and status structures. No dependencies.
package sld_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;

    localparam int BYTE_W          = 8;
    localparam int PAYLOAD_LEN_W   = 7;
    localparam int PAYLOAD_INDEX_W = 6;

    localparam logic [BYTE_W-1:0] SYNC_A_BYTE = 8'h53;
    localparam logic [BYTE_W-1:0] SYNC_B_BYTE = 8'h59;
    localparam logic [BYTE_W-1:0] TAIL_A_BYTE = 8'h54;
    localparam logic [BYTE_W-1:0] TAIL_B_BYTE = 8'h43;

    typedef enum logic [3:0] {
        ST_SYNC_A,
        ST_SYNC_B,
        ST_CTRL,
        ST_CMD,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_PAYLOAD,
        ST_SUM,
        ST_TAIL_A,
        ST_TAIL_B,
        ST_READ,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic sum_set;
        logic sum_add;
        logic sum_clr;
        logic load_ctrl;
        logic load_cmd;
        logic load_len_hi;
        logic load_len_lo;
        logic clr_count;
        logic wr_payload;
        logic rd_load;
        logic step_count;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_sync_a;
        logic is_sync_b;
        logic is_tail_a;
        logic is_tail_b;
        logic sum_match;
        logic len_zero;
        logic len_too_long;
        logic payload_done;
        logic out_last;
    } dp_status_t;

endpackage

FILE: sv/sld_ctrl.sv
// Controller state machine of the deframer: walks the frame fields,
// steers the datapath by commands and sequences the result run.
// Depends on sld_pkg.
module sld_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  out_stall,
    input  sld_pkg::dp_status_t   status,
    output sld_pkg::ctrl_cmd_t    cmd,
    output logic                  in_stall,
    output logic                  out_valid
);
    import sld_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   in_acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SYNC_A;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        in_stall   = (state_reg == ST_READ) || (state_reg == ST_OUT);
        out_valid  = (state_reg == ST_OUT);
        in_acc     = in_valid && !in_stall;
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_SYNC_A:
            begin
                if (in_acc && status.is_sync_a)
                begin
                    cmd.sum_set = 1'b1;
                    state_next  = ST_SYNC_B;
                end
            end
            ST_SYNC_B:
            begin
                if (in_acc)
                begin
                    if (status.is_sync_b)
                    begin
                        cmd.sum_add = 1'b1;
                        state_next  = ST_CTRL;
                    end
                    else
                    begin
                        cmd.sum_clr = 1'b1;
                        state_next  = ST_SYNC_A;
                    end
                end
            end
            ST_CTRL:
            begin
                if (in_acc)
                begin
                    cmd.load_ctrl = 1'b1;
                    cmd.sum_add   = 1'b1;
                    state_next    = ST_CMD;
                end
            end
            ST_CMD:
            begin
                if (in_acc)
                begin
                    cmd.load_cmd = 1'b1;
                    cmd.sum_add  = 1'b1;
                    state_next   = ST_LEN_HI;
                end
            end
            ST_LEN_HI:
            begin
                if (in_acc)
                begin
                    cmd.load_len_hi = 1'b1;
                    cmd.sum_add     = 1'b1;
                    state_next      = ST_LEN_LO;
                end
            end
            ST_LEN_LO:
            begin
                if (in_acc)
                begin
                    cmd.load_len_lo = 1'b1;
                    cmd.sum_add     = 1'b1;
                    cmd.clr_count   = 1'b1;
                    if (status.len_zero)
                    begin
                        state_next = ST_SUM;
                    end
                    else if (status.len_too_long)
                    begin
                        state_next = ST_SYNC_A;
                    end
                    else
                    begin
                        state_next = ST_PAYLOAD;
                    end
                end
            end
            ST_PAYLOAD:
            begin
                if (in_acc)
                begin
                    cmd.wr_payload = 1'b1;
                    cmd.sum_add    = 1'b1;
                    if (status.payload_done)
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                if (in_acc)
                begin
                    state_next = status.sum_match ? ST_TAIL_A : ST_SYNC_A;
                end
            end
            ST_TAIL_A:
            begin
                if (in_acc)
                begin
                    state_next = status.is_tail_a ? ST_TAIL_B : ST_SYNC_A;
                end
            end
            ST_TAIL_B:
            begin
                if (in_acc)
                begin
                    if (status.is_tail_b)
                    begin
                        cmd.clr_count = 1'b1;
                        state_next    = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_SYNC_A;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_load = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    if (status.out_last)
                    begin
                        state_next = ST_SYNC_A;
                    end
                    else
                    begin
                        cmd.step_count = 1'b1;
                        state_next     = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_SYNC_A;
            end
        endcase
    end

endmodule

FILE: sv/sld_dp.sv
// Datapath of the deframer: held header fields, running checksum, byte
// counter, payload memory and the result registers.
// Depends on sld_pkg.
module sld_dp #(
    parameter int MAX_PAYLOAD = sld_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [sld_pkg::BYTE_W-1:0]            rx_byte,
    input  sld_pkg::ctrl_cmd_t                    cmd,
    output sld_pkg::dp_status_t                   status,
    output logic [sld_pkg::BYTE_W-1:0]            frame_control,
    output logic [sld_pkg::BYTE_W-1:0]            frame_command,
    output logic [sld_pkg::PAYLOAD_LEN_W-1:0]     payload_length,
    output logic                                  has_payload,
    output logic [sld_pkg::PAYLOAD_INDEX_W-1:0]   payload_index,
    output logic [sld_pkg::BYTE_W-1:0]            payload_byte,
    output logic                                  last
);
    import sld_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [BYTE_W-1:0] ctrl_reg;
    logic [BYTE_W-1:0] cmd_reg;
    logic [BYTE_W-1:0] len_hi_reg;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [BYTE_W-1:0] sum_reg;

    logic [BYTE_W-1:0] mem [0:MAX_PAYLOAD-1];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]  out_index_reg;
    logic              out_has_reg;
    logic              out_last_reg;

    logic [CNT_W:0]    count_inc;
    logic              len_zero_held;

    assign count_inc     = {1'b0, count_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign len_zero_held = (len_reg == '0);

    always_comb
    begin
        status.is_sync_a    = (rx_byte == SYNC_A_BYTE);
        status.is_sync_b    = (rx_byte == SYNC_B_BYTE);
        status.is_tail_a    = (rx_byte == TAIL_A_BYTE);
        status.is_tail_b    = (rx_byte == TAIL_B_BYTE);
        status.sum_match    = (rx_byte == sum_reg);
        status.len_zero     = (len_hi_reg == '0) && (rx_byte == '0);
        status.len_too_long = (len_hi_reg != '0) || (rx_byte > BYTE_W'(MAX_PAYLOAD));
        status.payload_done = (count_inc == {1'b0, len_reg});
        status.out_last     = out_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            count_reg  <= '0;
            ctrl_reg   <= '0;
            cmd_reg    <= '0;
            len_hi_reg <= '0;
            len_reg    <= '0;
        end
        else
        begin
            if (cmd.sum_set)
            begin
                sum_reg <= rx_byte;
            end
            else if (cmd.sum_add)
            begin
                sum_reg <= sum_reg + rx_byte;
            end
            else if (cmd.sum_clr)
            begin
                sum_reg <= '0;
            end

            if (cmd.clr_count)
            begin
                count_reg <= '0;
            end
            else if (cmd.wr_payload || cmd.step_count)
            begin
                count_reg <= count_inc[CNT_W-1:0];
            end

            if (cmd.load_ctrl)
            begin
                ctrl_reg <= rx_byte;
            end
            if (cmd.load_cmd)
            begin
                cmd_reg <= rx_byte;
            end
            if (cmd.load_len_hi)
            begin
                len_hi_reg <= rx_byte;
            end
            if (cmd.load_len_lo)
            begin
                len_reg <= rx_byte[CNT_W-1:0];
            end
        end
    end

    // Payload memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_payload)
        begin
            mem[count_reg[IDX_W-1:0]] <= rx_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_load)
        begin
            rd_data_reg   <= mem[count_reg[IDX_W-1:0]];
            out_index_reg <= count_reg;
            out_has_reg   <= !len_zero_held;
            out_last_reg  <= len_zero_held || (count_inc == {1'b0, len_reg});
        end
    end

    assign frame_control  = ctrl_reg;
    assign frame_command  = cmd_reg;
    assign payload_length = PAYLOAD_LEN_W'(len_reg);
    assign has_payload    = out_has_reg;
    assign payload_index  = PAYLOAD_INDEX_W'(out_index_reg);
    assign payload_byte   = out_has_reg ? rd_data_reg : '0;
    assign last           = out_last_reg;

endmodule

FILE: sv/sync_length_checksum_deframer_top.sv
// Top level of the sync/length/checksum deframer.
// Instantiates the controller (sld_ctrl) and the datapath (sld_dp); uses sld_pkg.
//
// The block takes one received byte per request and parses frames of the form
// 0x53 0x59, control, command, 16-bit big-endian length, payload, an 8-bit
// additive checksum over all earlier bytes of the frame, then 0x54 0x43.
// While a frame is being parsed one byte is taken in every clock cycle in
// which in_valid is high. A frame whose length exceeds MAX_PAYLOAD, whose
// checksum is wrong or whose tail is wrong is dropped without notice, and the
// parser resumes hunting for the first sync byte; the byte that failed is not
// looked at again. When the last tail byte of a good frame arrives, the block
// delivers one result request per payload byte (or a single result with
// has_payload low for an empty frame), each carrying control, command and
// length, with last high on the final one. During that run in_stall is held
// high. Each result passes through the registered read of the payload memory
// and then the output register, where it waits while the consumer holds
// out_stall; the next byte is taken only once the run is over. The payload
// memory holds MAX_PAYLOAD bytes and needs no clearing after reset, as a frame
// only delivers entries it has just written.
module sync_length_checksum_deframer_top #(
    parameter int MAX_PAYLOAD = sld_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [sld_pkg::BYTE_W-1:0]            rx_byte,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [sld_pkg::BYTE_W-1:0]            frame_control,
    output logic [sld_pkg::BYTE_W-1:0]            frame_command,
    output logic [sld_pkg::PAYLOAD_LEN_W-1:0]     payload_length,
    output logic                                  has_payload,
    output logic [sld_pkg::PAYLOAD_INDEX_W-1:0]   payload_index,
    output logic [sld_pkg::BYTE_W-1:0]            payload_byte,
    output logic                                  last
);
    import sld_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // The controller owns the handshakes; the datapath sees only commands and the received byte.
    sld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    sld_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_byte        (rx_byte),
        .cmd            (cmd),
        .status         (status),
        .frame_control  (frame_control),
        .frame_command  (frame_command),
        .payload_length (payload_length),
        .has_payload    (has_payload),
        .payload_index  (payload_index),
        .payload_byte   (payload_byte),
        .last           (last)
    );

endmodule

FILE: sv/sld_checker.sv
// Port-level checker for the deframer top level, with its bind statement.
// Depends on sld_pkg and on sync_length_checksum_deframer_top.
module sld_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic [sld_pkg::BYTE_W-1:0]            rx_byte,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic [sld_pkg::BYTE_W-1:0]            frame_control,
    input  logic [sld_pkg::BYTE_W-1:0]            frame_command,
    input  logic [sld_pkg::PAYLOAD_LEN_W-1:0]     payload_length,
    input  logic                                  has_payload,
    input  logic [sld_pkg::PAYLOAD_INDEX_W-1:0]   payload_index,
    input  logic [sld_pkg::BYTE_W-1:0]            payload_byte,
    input  logic                                  last
);
    import sld_pkg::*;

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(payload_byte)
            && $stable(payload_index) && $stable(last) && $stable(has_payload))
        else $error("stalled result changed");

    // No byte is taken while a result run is being delivered.
    a_no_input_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken during result run");

    // An empty frame gives one terminal result with zeroed payload fields.
    a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_payload |-> last && payload_index == '0
            && payload_byte == '0 && payload_length == '0)
        else $error("malformed empty-frame result");

    // Payload positions stay within the announced length.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_payload |-> PAYLOAD_LEN_W'(payload_index) < payload_length)
        else $error("payload index beyond length");

    // Each taken result is followed by a cycle with no result, as the next
    // one has to be read back from the payload memory first.
    a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("results delivered back to back");

endmodule

bind sync_length_checksum_deframer_top sld_checker u_sld_checker (.*);
